### src/d2q9_pkg.sv
// Shared types, constants and fixed-point helpers for the D2Q9 BGK collision block.
package d2q9_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 28;
   localparam int RATE_BITS = 30;
   localparam int NUM_DIRS  = 9;
   localparam int NUM_MOVE  = 8;

   // One quotient bit of the reciprocal is resolved in each divider stage.
   localparam int DIV_STEPS = WORD_BITS - 1;
   localparam int REM_BITS  = WORD_BITS - 1;

   typedef logic signed [WORD_BITS-1:0]   word_type;
   typedef logic signed [2*WORD_BITS-1:0] wide_type;
   typedef logic [RATE_BITS-1:0]          rate_type;
   typedef logic [REM_BITS-1:0]           rem_type;

   typedef struct packed {
      word_type inv;
      logic     pos;
   } recip_type;

   localparam longint MAX_L = (longint'(1) <<< (WORD_BITS - 1)) - 1;
   localparam longint MIN_L = -MAX_L - 1;
   localparam longint ONE_L = longint'(1) <<< FRAC_BITS;

   localparam word_type ONE_Q      = word_type'(ONE_L);
   localparam word_type MAX_Q      = word_type'(MAX_L);
   localparam word_type THREE_HALF = word_type'(3 * (ONE_L / 2));
   localparam word_type W_REST     = word_type'((4 * ONE_L + 4) / 9);
   localparam word_type W_STRAIGHT = word_type'((ONE_L + 4) / 9);
   localparam word_type W_DIAG     = word_type'((ONE_L + 18) / 36);
   localparam rate_type RATE_RESET = rate_type'(ONE_L);

   // The numerator 2^(2F) is applied as its top bits; below this density the
   // reciprocal does not fit in a word and saturates.
   localparam int      REM_SHIFT = 2 * FRAC_BITS - (WORD_BITS - 1);
   localparam rem_type REM_INIT  = rem_type'(longint'(1) <<< REM_SHIFT);

   function automatic word_type sat64(wide_type v);
      word_type r;
      if (v > wide_type'(MAX_L)) begin
         r = word_type'(MAX_L);
      end else if (v < wide_type'(MIN_L)) begin
         r = word_type'(MIN_L);
      end else begin
         r = v[WORD_BITS-1:0];
      end
      return r;
   endfunction

   function automatic word_type add_sat(word_type a, word_type b);
      wide_type wa;
      wide_type wb;
      wa = wide_type'(a);
      wb = wide_type'(b);
      return sat64(wa + wb);
   endfunction

   function automatic word_type neg_sat(word_type a);
      wide_type wa;
      wa = wide_type'(a);
      return sat64(-wa);
   endfunction

   // Full product, floor shift by the fraction width, then saturation.
   function automatic word_type mulq(word_type a, word_type b);
      wide_type p;
      p = wide_type'(a) * wide_type'(b);
      return sat64(p >>> FRAC_BITS);
   endfunction

endpackage

### src/d2q9_recip.sv
// Pipelined restoring divider giving the saturated reciprocal of density.
module d2q9_recip (
   input  logic               clock,
   input  d2q9_pkg::word_type rho,
   output d2q9_pkg::recip_type recip
);
   import d2q9_pkg::*;

   rem_type                  rem_src [DIV_STEPS];
   logic [DIV_STEPS-1:0]     q_src   [DIV_STEPS];
   rem_type                  rho_src [DIV_STEPS];
   logic                     big_src [DIV_STEPS];
   logic                     pos_src [DIV_STEPS];

   rem_type                  rem_ff  [DIV_STEPS];
   logic [DIV_STEPS-1:0]     q_ff    [DIV_STEPS];
   rem_type                  rho_ff  [DIV_STEPS];
   logic                     big_ff  [DIV_STEPS];
   logic                     pos_ff  [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [REM_BITS:0] shifted;
      logic              ge;

      if (k == 0) begin : g_first
         assign rem_src[k] = REM_INIT;
         assign q_src[k]   = '0;
         assign rho_src[k] = rho[REM_BITS-1:0];
         assign pos_src[k] = (rho > word_type'(0));
         assign big_src[k] = (rho <= word_type'(longint'(1) <<< REM_SHIFT));
      end else begin : g_next
         assign rem_src[k] = rem_ff[k-1];
         assign q_src[k]   = q_ff[k-1];
         assign rho_src[k] = rho_ff[k-1];
         assign pos_src[k] = pos_ff[k-1];
         assign big_src[k] = big_ff[k-1];
      end

      assign shifted = {rem_src[k], 1'b0};
      assign ge      = (shifted >= {1'b0, rho_src[k]});

      always_ff @(posedge clock) begin
         if (ge) begin
            rem_ff[k] <= REM_BITS'(shifted - {1'b0, rho_src[k]});
         end else begin
            rem_ff[k] <= shifted[REM_BITS-1:0];
         end
         q_ff[k]   <= {q_src[k][DIV_STEPS-2:0], ge};
         rho_ff[k] <= rho_src[k];
         pos_ff[k] <= pos_src[k];
         big_ff[k] <= big_src[k];
      end
   end

   always_comb begin
      recip.pos = pos_ff[DIV_STEPS-1];
      if (big_ff[DIV_STEPS-1]) begin
         recip.inv = MAX_Q;
      end else begin
         recip.inv = word_type'({1'b0, q_ff[DIV_STEPS-1]});
      end
   end

endmodule

### src/d2q9_bgk_collision.sv
// Top level of the pipelined D2Q9 BGK collision for one lattice node per beat.
//
// The requester drives the nine streamed-in populations on the req_ ports and
// raises start; a beat is taken at every rising edge where start is high and
// busy is low. Busy is always low, because the datapath is a fully pipelined
// chain that takes a new node in every cycle, so one node per clock is the
// sustained rate.
// Each result beat (density, both velocities and nine post-collision
// populations) appears on the rsp_ ports for exactly one cycle, marked by
// rsp_strobe, after stage 1, the divider and stages 2 to 9. The receiver
// cannot stall, so results leave in request order with no holding stage.
// The latency is set by the reciprocal of density: a restoring divider that
// resolves one quotient bit per stage over 31 stages, followed by eight
// stages of multiply, add and saturate work.
// The user writes the relax rate through csr_we and csr_wdata only while no node
// is in flight, which the block does not enforce; derived products are registered.
// A synchronous reset clears all valid bits, so no stray result beat comes
// out, and sets the relax rate back to one.
module d2q9_bgk_collision (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  d2q9_pkg::word_type  req_pop_rest,
   input  d2q9_pkg::word_type  req_pop_east,
   input  d2q9_pkg::word_type  req_pop_north,
   input  d2q9_pkg::word_type  req_pop_west,
   input  d2q9_pkg::word_type  req_pop_south,
   input  d2q9_pkg::word_type  req_pop_ne,
   input  d2q9_pkg::word_type  req_pop_nw,
   input  d2q9_pkg::word_type  req_pop_sw,
   input  d2q9_pkg::word_type  req_pop_se,
   input  logic                csr_we,
   input  d2q9_pkg::rate_type  csr_wdata,
   output logic                rsp_strobe,
   output d2q9_pkg::word_type  rsp_density,
   output d2q9_pkg::word_type  rsp_vel_x,
   output d2q9_pkg::word_type  rsp_vel_y,
   output d2q9_pkg::word_type  rsp_out_rest,
   output d2q9_pkg::word_type  rsp_out_east,
   output d2q9_pkg::word_type  rsp_out_north,
   output d2q9_pkg::word_type  rsp_out_west,
   output d2q9_pkg::word_type  rsp_out_south,
   output d2q9_pkg::word_type  rsp_out_ne,
   output d2q9_pkg::word_type  rsp_out_nw,
   output d2q9_pkg::word_type  rsp_out_sw,
   output d2q9_pkg::word_type  rsp_out_se
);
   import d2q9_pkg::*;

   // Configuration and values derived from it.
   rate_type  relax_rate_ff;
   word_type  rate_w;
   word_type  om_ff;
   word_type  rw0_ff;
   word_type  rws_ff;
   word_type  rwd_ff;

   assign busy   = 1'b0;
   assign rate_w = word_type'({{(WORD_BITS-RATE_BITS){1'b0}}, relax_rate_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         relax_rate_ff <= RATE_RESET;
      end else if (csr_we) begin
         relax_rate_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      om_ff  <= add_sat(ONE_Q, neg_sat(rate_w));
      rw0_ff <= mulq(rate_w, W_REST);
      rws_ff <= mulq(rate_w, W_STRAIGHT);
      rwd_ff <= mulq(rate_w, W_DIAG);
   end

   // Stage 1: capture populations, form density and momenta.
   word_type  pop_in [NUM_DIRS];
   word_type  rho_in;
   word_type  mx_in;
   word_type  my_in;
   logic      v1_ff;
   word_type  f1_ff [NUM_DIRS];
   word_type  rho1_ff;
   word_type  mx1_ff;
   word_type  my1_ff;

   assign pop_in[0] = req_pop_rest;
   assign pop_in[1] = req_pop_east;
   assign pop_in[2] = req_pop_north;
   assign pop_in[3] = req_pop_west;
   assign pop_in[4] = req_pop_south;
   assign pop_in[5] = req_pop_ne;
   assign pop_in[6] = req_pop_nw;
   assign pop_in[7] = req_pop_sw;
   assign pop_in[8] = req_pop_se;

   always_comb begin
      wide_type acc;
      wide_type px;
      wide_type nx;
      wide_type py;
      wide_type ny;
      acc = '0;
      for (int i = 0; i < NUM_DIRS; i++) begin
         acc = acc + wide_type'(pop_in[i]);
      end
      rho_in = sat64(acc);
      px = wide_type'(pop_in[1]) + wide_type'(pop_in[5]) + wide_type'(pop_in[8]);
      nx = wide_type'(pop_in[3]) + wide_type'(pop_in[6]) + wide_type'(pop_in[7]);
      py = wide_type'(pop_in[2]) + wide_type'(pop_in[5]) + wide_type'(pop_in[6]);
      ny = wide_type'(pop_in[4]) + wide_type'(pop_in[7]) + wide_type'(pop_in[8]);
      mx_in = sat64(px - nx);
      my_in = sat64(py - ny);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      f1_ff   <= pop_in;
      rho1_ff <= rho_in;
      mx1_ff  <= mx_in;
      my1_ff  <= my_in;
   end

   // Reciprocal of density, with the node carried alongside in a delay line.
   recip_type recip;

   d2q9_recip u_recip (
      .clock (clock),
      .rho   (rho1_ff),
      .recip (recip)
   );

   logic      vd_ff   [DIV_STEPS];
   word_type  fd_ff   [DIV_STEPS][NUM_DIRS];
   word_type  rhod_ff [DIV_STEPS];
   word_type  mxd_ff  [DIV_STEPS];
   word_type  myd_ff  [DIV_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STEPS; k++) begin
            vd_ff[k] <= 1'b0;
         end
      end else begin
         vd_ff[0] <= v1_ff;
         for (int k = 1; k < DIV_STEPS; k++) begin
            vd_ff[k] <= vd_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      fd_ff[0]   <= f1_ff;
      rhod_ff[0] <= rho1_ff;
      mxd_ff[0]  <= mx1_ff;
      myd_ff[0]  <= my1_ff;
      for (int k = 1; k < DIV_STEPS; k++) begin
         fd_ff[k]   <= fd_ff[k-1];
         rhod_ff[k] <= rhod_ff[k-1];
         mxd_ff[k]  <= mxd_ff[k-1];
         myd_ff[k]  <= myd_ff[k-1];
      end
   end

   // Stage 2: velocities; zero when density is not positive.
   logic      v2_ff;
   word_type  f2_ff [NUM_DIRS];
   word_type  rho2_ff;
   word_type  ux2_ff;
   word_type  uy2_ff;

   always_ff @(posedge clock) begin
      f2_ff   <= fd_ff[DIV_STEPS-1];
      rho2_ff <= rhod_ff[DIV_STEPS-1];
      if (recip.pos) begin
         ux2_ff <= mulq(recip.inv, mxd_ff[DIV_STEPS-1]);
         uy2_ff <= mulq(recip.inv, myd_ff[DIV_STEPS-1]);
      end else begin
         ux2_ff <= '0;
         uy2_ff <= '0;
      end
   end

   // Stage 3: squared velocities, scaled velocities and weighted densities.
   logic      v3_ff;
   word_type  f3_ff [NUM_DIRS];
   word_type  rho3_ff;
   word_type  ux3_ff;
   word_type  uy3_ff;
   word_type  uxx3_ff;
   word_type  uyy3_ff;
   word_type  tux3_ff;
   word_type  tuy3_ff;
   word_type  tw03_ff;
   word_type  tws3_ff;
   word_type  twd3_ff;

   always_ff @(posedge clock) begin
      f3_ff   <= f2_ff;
      rho3_ff <= rho2_ff;
      ux3_ff  <= ux2_ff;
      uy3_ff  <= uy2_ff;
      uxx3_ff <= mulq(ux2_ff, ux2_ff);
      uyy3_ff <= mulq(uy2_ff, uy2_ff);
      tux3_ff <= sat64(wide_type'(ux2_ff) * 3);
      tuy3_ff <= sat64(wide_type'(uy2_ff) * 3);
      tw03_ff <= mulq(rw0_ff, rho2_ff);
      tws3_ff <= mulq(rws_ff, rho2_ff);
      twd3_ff <= mulq(rwd_ff, rho2_ff);
   end

   // Stage 4: speed squared and the projection c = 3 e_i.u for each moving direction.
   logic      v4_ff;
   word_type  f4_ff [NUM_DIRS];
   word_type  rho4_ff;
   word_type  ux4_ff;
   word_type  uy4_ff;
   word_type  usq4_ff;
   word_type  c4_ff [NUM_MOVE];
   word_type  tw04_ff;
   word_type  tws4_ff;
   word_type  twd4_ff;

   always_ff @(posedge clock) begin
      f4_ff    <= f3_ff;
      rho4_ff  <= rho3_ff;
      ux4_ff   <= ux3_ff;
      uy4_ff   <= uy3_ff;
      tw04_ff  <= tw03_ff;
      tws4_ff  <= tws3_ff;
      twd4_ff  <= twd3_ff;
      usq4_ff  <= add_sat(uxx3_ff, uyy3_ff);
      c4_ff[0] <= tux3_ff;
      c4_ff[1] <= tuy3_ff;
      c4_ff[2] <= neg_sat(tux3_ff);
      c4_ff[3] <= neg_sat(tuy3_ff);
      c4_ff[4] <= add_sat(tux3_ff, tuy3_ff);
      c4_ff[5] <= sat64(wide_type'(tuy3_ff) - wide_type'(tux3_ff));
      c4_ff[6] <= sat64(-wide_type'(tux3_ff) - wide_type'(tuy3_ff));
      c4_ff[7] <= sat64(wide_type'(tux3_ff) - wide_type'(tuy3_ff));
   end

   // Stage 5: 1 - 1.5 u.u and 1 + c/2.
   logic      v5_ff;
   word_type  f5_ff [NUM_DIRS];
   word_type  rho5_ff;
   word_type  ux5_ff;
   word_type  uy5_ff;
   word_type  omusq5_ff;
   word_type  c5_ff [NUM_MOVE];
   word_type  a5_ff [NUM_MOVE];
   word_type  tw05_ff;
   word_type  tws5_ff;
   word_type  twd5_ff;

   always_ff @(posedge clock) begin
      f5_ff     <= f4_ff;
      rho5_ff   <= rho4_ff;
      ux5_ff    <= ux4_ff;
      uy5_ff    <= uy4_ff;
      tw05_ff   <= tw04_ff;
      tws5_ff   <= tws4_ff;
      twd5_ff   <= twd4_ff;
      c5_ff     <= c4_ff;
      omusq5_ff <= add_sat(ONE_Q, neg_sat(mulq(THREE_HALF, usq4_ff)));
      for (int i = 0; i < NUM_MOVE; i++) begin
         a5_ff[i] <= add_sat(ONE_Q, c4_ff[i] >>> 1);
      end
   end

   // Stage 6: c (1 + c/2) and the non-equilibrium part (1 - rate) f.
   logic      v6_ff;
   word_type  rho6_ff;
   word_type  ux6_ff;
   word_type  uy6_ff;
   word_type  omusq6_ff;
   word_type  m6_ff   [NUM_MOVE];
   word_type  omf6_ff [NUM_DIRS];
   word_type  tw06_ff;
   word_type  tws6_ff;
   word_type  twd6_ff;

   always_ff @(posedge clock) begin
      rho6_ff   <= rho5_ff;
      ux6_ff    <= ux5_ff;
      uy6_ff    <= uy5_ff;
      omusq6_ff <= omusq5_ff;
      tw06_ff   <= tw05_ff;
      tws6_ff   <= tws5_ff;
      twd6_ff   <= twd5_ff;
      for (int i = 0; i < NUM_MOVE; i++) begin
         m6_ff[i] <= mulq(c5_ff[i], a5_ff[i]);
      end
      for (int i = 0; i < NUM_DIRS; i++) begin
         omf6_ff[i] <= mulq(om_ff, f5_ff[i]);
      end
   end

   // Stage 7: bracketed equilibrium term for each moving direction.
   logic      v7_ff;
   word_type  rho7_ff;
   word_type  ux7_ff;
   word_type  uy7_ff;
   word_type  omusq7_ff;
   word_type  inner7_ff [NUM_MOVE];
   word_type  omf7_ff   [NUM_DIRS];
   word_type  tw07_ff;
   word_type  tws7_ff;
   word_type  twd7_ff;

   always_ff @(posedge clock) begin
      rho7_ff   <= rho6_ff;
      ux7_ff    <= ux6_ff;
      uy7_ff    <= uy6_ff;
      omusq7_ff <= omusq6_ff;
      omf7_ff   <= omf6_ff;
      tw07_ff   <= tw06_ff;
      tws7_ff   <= tws6_ff;
      twd7_ff   <= twd6_ff;
      for (int i = 0; i < NUM_MOVE; i++) begin
         inner7_ff[i] <= add_sat(omusq6_ff, m6_ff[i]);
      end
   end

   // Stage 8: weighted equilibrium for all nine directions.
   logic      v8_ff;
   word_type  rho8_ff;
   word_type  ux8_ff;
   word_type  uy8_ff;
   word_type  t8_ff   [NUM_DIRS];
   word_type  omf8_ff [NUM_DIRS];

   always_ff @(posedge clock) begin
      rho8_ff  <= rho7_ff;
      ux8_ff   <= ux7_ff;
      uy8_ff   <= uy7_ff;
      omf8_ff  <= omf7_ff;
      t8_ff[0] <= mulq(tw07_ff, omusq7_ff);
      for (int i = 0; i < NUM_MOVE; i++) begin
         if (i < 4) begin
            t8_ff[i+1] <= mulq(tws7_ff, inner7_ff[i]);
         end else begin
            t8_ff[i+1] <= mulq(twd7_ff, inner7_ff[i]);
         end
      end
   end

   // Stage 9: final relaxation sum into the result registers.
   logic      v9_ff;
   word_type  rho9_ff;
   word_type  ux9_ff;
   word_type  uy9_ff;
   word_type  out9_ff [NUM_DIRS];

   always_ff @(posedge clock) begin
      rho9_ff <= rho8_ff;
      ux9_ff  <= ux8_ff;
      uy9_ff  <= uy8_ff;
      for (int i = 0; i < NUM_DIRS; i++) begin
         out9_ff[i] <= add_sat(omf8_ff[i], t8_ff[i]);
      end
   end

   // Valid bits for stages 2 through 9.
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else begin
         v2_ff <= vd_ff[DIV_STEPS-1];
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   assign rsp_strobe    = v9_ff;
   assign rsp_density   = rho9_ff;
   assign rsp_vel_x     = ux9_ff;
   assign rsp_vel_y     = uy9_ff;
   assign rsp_out_rest  = out9_ff[0];
   assign rsp_out_east  = out9_ff[1];
   assign rsp_out_north = out9_ff[2];
   assign rsp_out_west  = out9_ff[3];
   assign rsp_out_south = out9_ff[4];
   assign rsp_out_ne    = out9_ff[5];
   assign rsp_out_nw    = out9_ff[6];
   assign rsp_out_sw    = out9_ff[7];
   assign rsp_out_se    = out9_ff[8];

endmodule
